// File: src/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared codes and character constants for the integer to ASCII digits unit.
// ----------------------------------------------------------------------------
package itoa_pkg;

  // Base selector codes
  localparam logic [1:0] REQ_DEC  = 2'd0;
  localparam logic [1:0] REQ_HEX  = 2'd1;
  localparam logic [1:0] REQ_BIN  = 2'd2;
  localparam logic [1:0] REQ_DEC3 = 2'd3;

  // ASCII characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ALPHA = 8'h41;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  // Digit register geometry: 20 nibbles hold any decimal magnitude
  localparam int DIG_W     = 80;
  localparam int DEC_DIGS  = 20;
  localparam int MAG_W     = 64;

  typedef logic [DIG_W-1:0] dig_t;

  // Map one digit value to its character, uppercase for ten and above
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d > 4'd9) begin
      c = CH_ALPHA + {4'b0, d} - 8'd10;
    end else begin
      c = CH_ZERO + {4'b0, d};
    end
    return c;
  endfunction

endpackage

// File: src/itoa_in_if.sv
// ----------------------------------------------------------------------------
// itoa_in_if
// Input channel: one signed integer with its mode and base selector.
// ----------------------------------------------------------------------------
interface itoa_in_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic               wide_mode;
  logic [1:0]         req_type;

  modport source (output valid, output value, output wide_mode, output req_type,
                  input ready);
  modport sink (input valid, input value, input wide_mode, input req_type,
                output ready);
endinterface

// File: src/itoa_out_if.sv
// ----------------------------------------------------------------------------
// itoa_out_if
// Output channel: one ASCII character with a final-character flag.
// ----------------------------------------------------------------------------
interface itoa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink (input valid, input out_char, input last_char, output ready);
endinterface

// File: src/integer_to_ascii_digits_unit.sv
// Throughput: one character per cycle while chars.ready holds, set by the
//   single output register; the next item is taken once the last character
//   sits in that register.
// Decimal conversion is a bit-serial shift-add-3 loop, one input bit a cycle.
// Reset (synchronous, active high) returns to idle and drops any pending item.
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_unit
// Converts one integer to decimal, hex or binary text; wide binary gives decimal.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits_unit
  import itoa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  itoa_in_if.sink    number,
  itoa_out_if.source chars
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_SKIP,
    ST_EMIT
  } state_t;

  state_t             state;
  dig_t               dig;
  dig_t               dig_adj;
  logic [MAG_W-1:0]   mag;
  logic [6:0]         cnt;
  logic [5:0]         rem;
  logic               dsize4;
  logic               neg_pend;
  logic               o_valid;
  logic [7:0]         o_char;
  logic               o_last;

  logic               accept;
  logic               slot_free;
  logic               is_dec;
  logic               neg;
  logic [3:0]         top_dig;
  dig_t               dig_shift;
  logic [MAG_W-1:0]   mag64;
  logic [31:0]        mag32;

  assign accept    = number.valid && number.ready;
  assign slot_free = !o_valid || chars.ready;
  assign number.ready = (state == ST_IDLE);

  assign chars.valid     = o_valid;
  assign chars.out_char  = o_char;
  assign chars.last_char = o_last;

  // Decode base and sign of the incoming item
  always_comb begin
    unique case (number.req_type)
      REQ_HEX:  is_dec = 1'b0;
      REQ_BIN:  is_dec = number.wide_mode;
      REQ_DEC,
      REQ_DEC3: is_dec = 1'b1;
      default:  is_dec = 1'b1;
    endcase
    neg   = number.wide_mode ? number.value[63] : number.value[31];
    mag64 = number.value[63] ? (64'd0 - number.value) : number.value;
    mag32 = number.value[31] ? (32'd0 - number.value[31:0]) : number.value[31:0];
  end

  // Add 3 to every BCD digit of 5 or more before the next shift
  always_comb begin
    for (int i = 0; i < DEC_DIGS; i++) begin
      dig_adj[i*4 +: 4] = (dig[i*4 +: 4] >= 4'd5) ? dig[i*4 +: 4] + 4'd3
                                                  : dig[i*4 +: 4];
    end
  end

  // Leading digit and the register after it is dropped
  always_comb begin
    top_dig   = dsize4 ? dig[DIG_W-1 -: 4] : {3'b0, dig[DIG_W-1]};
    dig_shift = dsize4 ? {dig[DIG_W-5:0], 4'b0} : {dig[DIG_W-2:0], 1'b0};
  end

  // Sequencer: load, convert, drop leading zeros, emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      o_valid  <= 1'b0;
      neg_pend <= 1'b0;
    end else begin
      // Drop the held item once taken, unless a new one replaces it
      if (chars.ready && !(state == ST_EMIT && slot_free)) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            neg_pend <= neg && is_dec;
            if (is_dec) begin
              dig    <= '0;
              dsize4 <= 1'b1;
              rem    <= 6'(DEC_DIGS);
              mag    <= number.wide_mode ? mag64 : {mag32, 32'b0};
              cnt    <= number.wide_mode ? 7'd64 : 7'd32;
              state  <= ST_DABBLE;
            end else if (number.wide_mode) begin
              dig    <= {number.value, 16'b0};
              dsize4 <= 1'b1;
              rem    <= 6'd16;
              state  <= ST_SKIP;
            end else begin
              dig    <= {number.value[31:0], 48'b0};
              dsize4 <= (number.req_type == REQ_HEX);
              rem    <= (number.req_type == REQ_HEX) ? 6'd8 : 6'd32;
              state  <= ST_SKIP;
            end
          end
        end
        ST_DABBLE: begin
          if (cnt != 7'd0) begin
            dig <= {dig_adj[DIG_W-2:0], mag[MAG_W-1]};
            mag <= {mag[MAG_W-2:0], 1'b0};
            cnt <= cnt - 7'd1;
          end else begin
            state <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (rem > 6'd1 && top_dig == 4'd0) begin
            dig <= dig_shift;
            rem <= rem - 6'd1;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            o_valid <= 1'b1;
            if (neg_pend) begin
              o_char   <= CH_MINUS;
              o_last   <= 1'b0;
              neg_pend <= 1'b0;
            end else begin
              o_char <= digit_char(top_dig);
              o_last <= (rem == 6'd1);
              dig    <= dig_shift;
              rem    <= rem - 6'd1;
              if (rem == 6'd1) begin
                state <= ST_IDLE;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  logic bcd_ok;

  always_comb begin
    bcd_ok = 1'b1;
    for (int i = 0; i < DEC_DIGS; i++) begin
      if (dig[i*4 +: 4] > 4'd9) begin
        bcd_ok = 1'b0;
      end
    end
  end

  // Digit count never runs out while text remains
  a_rem_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SKIP || state == ST_EMIT) |-> rem != 6'd0)
    else $error("digit count empty during emit");

  // A minus sign is never the final character
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (chars.valid && chars.last_char) |-> chars.out_char != CH_MINUS)
    else $error("minus sign flagged as last character");

  // Decimal conversion keeps every digit in BCD range
  a_bcd_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DABBLE && dsize4) |-> bcd_ok)
    else $error("BCD digit out of range");

  // A new item is only taken after the previous final character was issued
  a_accept_after_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && $past(state) == ST_EMIT && state != ST_IDLE) |=>
      (state != ST_IDLE) || (o_valid && o_last))
    else $error("left emit without issuing final character");
`endif

endmodule
